/* src/tle_pkg.sv */
// Package for the terminal line editor: sizes, actions, register indices, byte codes, escape states.
// No dependencies.
package tle_pkg;
    localparam int LINE_DEPTH = 32;
    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int LEN_W = 6;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] REG_ECHO  = 2'd0;
    localparam logic [1:0] REG_BELL  = 2'd1;
    localparam logic [1:0] REG_ERASE = 2'd2;
    localparam logic [1:0] REG_ENTER = 2'd3;

    localparam logic [7:0] KEY_ESC = 8'h1B;
    localparam logic [7:0] KEY_BEL = 8'h07;
    localparam logic [7:0] KEY_BS  = 8'h08;
    localparam logic [7:0] KEY_LBR = 8'h5B;
    localparam logic [7:0] KEY_P   = 8'h50;
    localparam logic [7:0] KEY_RBR = 8'h5D;
    localparam logic [7:0] KEY_C   = 8'h43;
    localparam logic [7:0] KEY_D   = 8'h44;
    localparam logic [7:0] KEY_CR  = 8'h0D;
    localparam logic [7:0] KEY_LF  = 8'h0A;
    localparam logic [7:0] KEY_SP  = 8'h20;
    localparam logic [7:0] KEY_0   = 8'h30;

    localparam logic [2:0] ESC_NONE = 3'd0;
    localparam logic [2:0] ESC_SEEN = 3'd1;
    localparam logic [2:0] ESC_CSI  = 3'd2;
    localparam logic [2:0] ESC_DCS  = 3'd3;
    localparam logic [2:0] ESC_OSC  = 3'd4;
endpackage

/* src/terminal_line_editor.sv */
// Terminal line editor top level: escape parser, line store, echo sequencer.
// Depends on tle_pkg.
//
//  channel | ports                          | handshake
//  input   | s_action s_char_in s_read_index | s_valid / s_ready
//  result  | m_out_valid .. m_last           | m_valid / m_ready
//  config  | cfg_we cfg_index cfg_data       | write on cfg_we
//
// Each word is decoded in the DECODE state. An insert or mid-line erase then
// shifts the line store one entry per cycle. Each echo byte passes through
// the result register (a line byte is read from the store first) and is
// stalled by m_ready.
// Reset clears the cursor, length and escape state; the store is not swept.
// s_ready is low from acceptance until the last result word is taken.
module terminal_line_editor import tle_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    input  logic [7:0]       s_char_in,
    input  logic [4:0]       s_read_index,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_out_valid,
    output logic [7:0]       m_out_byte,
    output logic             m_line_done,
    output logic [5:0]       m_line_length,
    output logic [5:0]       m_cursor_pos,
    output logic [7:0]       m_read_char,
    output logic             m_last,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SHIFT, ST_CLEAR, ST_READ,
        ST_EMIT, ST_WAIT, ST_NONE
    } state_t;

    // Echo jobs: fixed bytes only, or a redraw of fixed bytes, line bytes and tail.
    typedef enum logic [3:0] {
        EM_END, EM_BEL, EM_CHAR, EM_ERASE3, EM_CRLF, EM_MOVE,
        EM_INS, EM_DEL
    } emit_t;

    state_t             state_reg;
    emit_t              job_reg;
    logic [7:0]         mem [LINE_DEPTH];
    logic [LEN_W-1:0]   len_reg, cur_reg;
    logic [2:0]         esc_reg;
    logic               echo_reg, bell_reg;
    logic [7:0]         erase_reg, enter_reg;
    logic [1:0]         act_reg;
    logic [7:0]         chr_reg;
    logic [4:0]         ridx_reg;
    logic [LEN_W-1:0]   ptr_reg;      // shift/clear/emit pointer
    logic [3:0]         step_reg;     // fixed-byte step within a job
    logic [7:0]         rd_reg;       // registered store read
    logic               done_reg;
    logic [7:0]         rchar_reg;
    logic [7:0]         dir_reg;
    logic [LEN_W-1:0]   num_reg;      // count for ESC [ n dir
    logic               shift_up_reg; // insert shifts up, erase shifts down

    logic [7:0] byte_w;
    logic       more_w;
    logic [3:0] tens_w;
    logic [3:0] ones_w;
    logic       shift_w;

    assign s_ready = (state_reg == ST_IDLE);

    // Tens and ones of a count below 64: small compare chain.
    always_comb begin
        tens_w = 4'd0;
        if (num_reg >= 6'd60) tens_w = 4'd6;
        else if (num_reg >= 6'd50) tens_w = 4'd5;
        else if (num_reg >= 6'd40) tens_w = 4'd4;
        else if (num_reg >= 6'd30) tens_w = 4'd3;
        else if (num_reg >= 6'd20) tens_w = 4'd2;
        else if (num_reg >= 6'd10) tens_w = 4'd1;
        ones_w = 4'(num_reg - 6'(tens_w) * 6'd10);
    end

    // Flag a received byte that edits mid-line and needs the store shifted.
    always_comb begin
        shift_w = 1'b0;
        if (act_reg == ACT_BYTE && chr_reg != KEY_ESC &&
            !(esc_reg inside {ESC_SEEN, ESC_CSI, ESC_DCS, ESC_OSC})) begin
            if (chr_reg == erase_reg) begin
                shift_w = (len_reg != '0) && (cur_reg != '0) && (cur_reg != len_reg);
            end else if (chr_reg != enter_reg) begin
                shift_w = (len_reg < 6'(LINE_DEPTH)) && (cur_reg != len_reg);
            end
        end
    end

    // Pick the byte for the current step; more_w says another byte follows.
    always_comb begin
        byte_w = 8'd0;
        more_w = 1'b0;
        case (job_reg)
            EM_BEL: byte_w = KEY_BEL;
            EM_CHAR: byte_w = chr_reg;
            EM_ERASE3: begin
                byte_w = (step_reg == 4'd1) ? KEY_SP : erase_reg;
                more_w = (step_reg != 4'd2);
            end
            EM_CRLF: begin
                byte_w = (step_reg == 4'd0) ? KEY_CR : KEY_LF;
                more_w = (step_reg == 4'd0);
            end
            EM_MOVE: begin
                byte_w = (step_reg == 4'd0) ? KEY_ESC :
                         (step_reg == 4'd1) ? KEY_LBR : dir_reg;
                more_w = (step_reg != 4'd2);
            end
            EM_INS, EM_DEL: begin
                // step 0: BS (erase only), 1: line bytes, 2: space (erase),
                // 3: ESC, 4: [, 5: tens, 6: ones, 7: D
                case (step_reg)
                    4'd0: byte_w = KEY_BS;
                    4'd1: byte_w = rd_reg;
                    4'd2: byte_w = KEY_SP;
                    4'd3: byte_w = KEY_ESC;
                    4'd4: byte_w = KEY_LBR;
                    4'd5: byte_w = KEY_0 + 8'(tens_w);
                    4'd6: byte_w = KEY_0 + 8'(ones_w);
                    default: byte_w = KEY_D;
                endcase
                more_w = (step_reg != 4'd7);
            end
            default: ;
        endcase
    end

    // Next step of a redraw job after the current byte.
    function automatic logic [3:0] after_step(input emit_t j, input logic [3:0] s,
                                             input logic line_more, input logic big);
        logic [3:0] r;
        r = s + 4'd1;
        case (s)
            4'd0: r = 4'd1;
            4'd1: r = line_more ? 4'd1 : ((j == EM_DEL) ? 4'd2 : 4'd3);
            4'd4: r = big ? 4'd5 : 4'd6;
            default: r = s + 4'd1;
        endcase
        return r;
    endfunction

    // Control, store and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            esc_reg   <= ESC_NONE;
            echo_reg  <= 1'b1;
            bell_reg  <= 1'b1;
            erase_reg <= 8'd127;
            enter_reg <= 8'd13;
            m_valid   <= 1'b0;
            job_reg   <= EM_END;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ECHO:  echo_reg  <= cfg_data[0];
                    REG_BELL:  bell_reg  <= cfg_data[0];
                    REG_ERASE: erase_reg <= cfg_data;
                    REG_ENTER: enter_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_action;
                        chr_reg   <= s_char_in;
                        ridx_reg  <= s_read_index;
                        done_reg  <= 1'b0;
                        rchar_reg <= 8'd0;
                        job_reg   <= EM_END;
                        step_reg  <= 4'd0;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (act_reg == ACT_BYTE) state_reg <= shift_w ? ST_SHIFT : ST_EMIT;
                    if (act_reg == ACT_READ) begin
                        rd_reg    <= mem[ridx_reg[IDX_W-1:0]];
                        state_reg <= ST_READ;
                    end else if (act_reg == ACT_CLEAR) begin
                        len_reg <= '0;
                        cur_reg <= '0;
                        esc_reg <= ESC_NONE;
                        ptr_reg <= '0;
                        state_reg <= ST_CLEAR;
                    end else if (act_reg != ACT_BYTE) begin
                        state_reg <= ST_EMIT;
                    end else if (chr_reg == KEY_ESC) begin
                        esc_reg <= ESC_SEEN;
                    end else if (esc_reg == ESC_SEEN) begin
                        esc_reg <= (chr_reg == KEY_LBR) ? ESC_CSI :
                                   (chr_reg == KEY_P)   ? ESC_DCS :
                                   (chr_reg == KEY_RBR) ? ESC_OSC : ESC_NONE;
                    end else if (esc_reg == ESC_CSI) begin
                        esc_reg <= ESC_NONE;
                        if (chr_reg == KEY_C) begin
                            if (cur_reg < len_reg) begin
                                cur_reg <= cur_reg + 6'd1;
                                dir_reg <= KEY_C;
                                job_reg <= EM_MOVE;
                            end else if (bell_reg) job_reg <= EM_BEL;
                        end else if (chr_reg == KEY_D) begin
                            if (cur_reg != '0) begin
                                cur_reg <= cur_reg - 6'd1;
                                dir_reg <= KEY_D;
                                job_reg <= EM_MOVE;
                            end else if (bell_reg) job_reg <= EM_BEL;
                        end
                    end else if (esc_reg == ESC_DCS || esc_reg == ESC_OSC) begin
                        esc_reg <= ESC_NONE;
                    end else begin
                        esc_reg <= ESC_NONE;
                        if (chr_reg == erase_reg) begin
                            if (len_reg == '0 || cur_reg == '0) begin
                                if (bell_reg) job_reg <= EM_BEL;
                            end else if (cur_reg != len_reg) begin
                                // Shift down from cursor-1, then redraw.
                                ptr_reg      <= cur_reg - 6'd1;
                                shift_up_reg <= 1'b0;
                                num_reg      <= len_reg - cur_reg + 6'd1;
                                len_reg      <= len_reg - 6'd1;
                                cur_reg      <= cur_reg - 6'd1;
                                if (echo_reg) job_reg <= EM_DEL;
                            end else begin
                                mem[IDX_W'(len_reg - 6'd1)] <= 8'd0;
                                len_reg <= len_reg - 6'd1;
                                cur_reg <= cur_reg - 6'd1;
                                if (echo_reg) job_reg <= EM_ERASE3;
                            end
                        end else if (chr_reg == enter_reg) begin
                            done_reg <= 1'b1;
                            if (echo_reg) job_reg <= EM_CRLF;
                        end else if (len_reg >= 6'(LINE_DEPTH)) begin
                            if (bell_reg) job_reg <= EM_BEL;
                        end else if (cur_reg != len_reg) begin
                            // Shift up from the end down to the cursor.
                            ptr_reg      <= len_reg;
                            shift_up_reg <= 1'b1;
                            num_reg      <= len_reg - cur_reg;
                            len_reg      <= len_reg + 6'd1;
                            if (echo_reg) job_reg <= EM_INS;
                            step_reg     <= 4'd1;
                        end else begin
                            mem[IDX_W'(len_reg)] <= chr_reg;
                            len_reg <= len_reg + 6'd1;
                            cur_reg <= cur_reg + 6'd1;
                            if (echo_reg) job_reg <= EM_CHAR;
                        end
                    end
                end
                ST_SHIFT: begin
                    // One entry per cycle; cur/len already hold final values
                    // for erase; insert moves cursor at the end.
                    if (shift_up_reg) begin
                        if (ptr_reg > cur_reg) begin
                            mem[IDX_W'(ptr_reg)] <= mem[IDX_W'(ptr_reg - 6'd1)];
                            ptr_reg <= ptr_reg - 6'd1;
                        end else begin
                            mem[IDX_W'(cur_reg)] <= chr_reg;
                            ptr_reg   <= cur_reg;
                            cur_reg   <= cur_reg + 6'd1;
                            state_reg <= ST_READ;
                        end
                    end else begin
                        if (ptr_reg < len_reg) begin
                            mem[IDX_W'(ptr_reg)] <= mem[IDX_W'(ptr_reg + 6'd1)];
                            ptr_reg <= ptr_reg + 6'd1;
                        end else begin
                            mem[IDX_W'(len_reg)] <= 8'd0;
                            ptr_reg   <= cur_reg;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_CLEAR: begin
                    mem[IDX_W'(ptr_reg)] <= 8'd0;
                    ptr_reg <= ptr_reg + 6'd1;
                    if (ptr_reg == 6'(LINE_DEPTH - 1)) state_reg <= ST_EMIT;
                end
                ST_READ: begin
                    // Fetch the entry at ptr for redraw, or the read result.
                    if (act_reg == ACT_READ) begin
                        rchar_reg <= rd_reg;
                    end else begin
                        rd_reg <= mem[IDX_W'(ptr_reg)];
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    m_valid       <= 1'b1;
                    m_out_valid   <= (job_reg != EM_END);
                    m_out_byte    <= byte_w;
                    m_line_done   <= done_reg;
                    m_line_length <= len_reg;
                    m_cursor_pos  <= cur_reg;
                    m_read_char   <= rchar_reg;
                    if (job_reg == EM_INS || job_reg == EM_DEL) begin
                        m_last <= (step_reg == 4'd7);
                    end else begin
                        m_last <= !more_w;
                    end
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (m_last) begin
                            state_reg <= ST_IDLE;
                        end else if (job_reg == EM_INS || job_reg == EM_DEL) begin
                            if (step_reg == 4'd1) begin
                                ptr_reg <= ptr_reg + 6'd1;
                                if (ptr_reg + 6'd1 < len_reg) begin
                                    state_reg <= ST_READ;
                                end else begin
                                    step_reg  <= after_step(job_reg, step_reg,
                                                            1'b0, 1'b0);
                                    state_reg <= ST_EMIT;
                                end
                            end else begin
                                // Erase with nothing after the cursor: skip line.
                                if (step_reg == 4'd0 && cur_reg >= len_reg) begin
                                    step_reg <= 4'd2;
                                end else begin
                                    step_reg <= after_step(job_reg, step_reg, 1'b0,
                                                           num_reg >= 6'd10);
                                end
                                state_reg <= (step_reg == 4'd0 && cur_reg < len_reg) ?
                                             ST_READ : ST_EMIT;
                            end
                        end else begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
